// ----- src/bfgw_pkg.sv -----
// Package with the shared types and constants of the grayscale range-weighted filter.
`default_nettype none
package bfgw_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned COORD_W    = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned ADDR_W     = COORD_W + ROW_W;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned RAD_W      = 3;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 9'd256;
  localparam logic [RAD_W-1:0]  RADIUS_RST = 3'd1;
  localparam logic [PIX_W-1:0]  LIMIT_RST  = 8'd15;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT        = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WRITE,
    ST_BACK,
    ST_CENTRE,
    ST_SCAN,
    ST_DRAIN,
    ST_DSTART,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

// ----- src/bfgw_divider.sv -----
// Restoring divider that forms the window mean one quotient bit per cycle.
`default_nettype none
module bfgw_divider (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [bfgw_pkg::SUM_W-1:0]      dividend,
  input  wire logic [bfgw_pkg::CNT_W-1:0]      divisor,
  output bfgw_pkg::div_sts_t                   sts,
  output logic      [bfgw_pkg::PIX_W-1:0]      quotient
);

  localparam int unsigned STEP_W = $clog2(bfgw_pkg::SUM_W + 1);

  logic                          busy_r;
  logic                          done_r;
  logic [STEP_W-1:0]             step_r;
  logic [bfgw_pkg::CNT_W:0]      rem_r;
  logic [bfgw_pkg::SUM_W-1:0]    quo_r;
  logic [bfgw_pkg::CNT_W-1:0]    div_r;
  logic [bfgw_pkg::CNT_W:0]      rem_s;
  logic                          fits;

  assign rem_s = {rem_r[bfgw_pkg::CNT_W-1:0], quo_r[bfgw_pkg::SUM_W-1]};
  assign fits  = rem_s >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(bfgw_pkg::SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= (divisor == '0) ? bfgw_pkg::CNT_W'(1) : divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_s - {1'b0, div_r}) : rem_s;
      quo_r <= {quo_r[bfgw_pkg::SUM_W-2:0], fits};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r[bfgw_pkg::PIX_W-1:0];

endmodule
`default_nettype wire

// ----- src/bilateral_filter_gray_wrap_core.sv -----
// Top level of the grayscale range-weighted filter with its frame store and sequencer.
`default_nettype none
// A load transaction (operation 0) writes one pixel into a 256 x 256 frame store: the
// sequencer first reduces column and row modulo the frame size, then writes. A query
// transaction (operation 1) for window radius r (at most 7) does the same reduction, then
// steps r times to the window corner, then reads the single-port frame store once per window
// pixel, and a restoring divider forms the mean. One transaction is in work at a time; a
// finished result waits in the output register while the next transaction is accepted.
// The frame store has no reset and must be loaded before it is queried. Configuration
// writes are always accepted and are meant for idle time.
module bilateral_filter_gray_wrap_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_operation,
  input  wire logic [bfgw_pkg::COORD_W-1:0]       in_column,
  input  wire logic [bfgw_pkg::ROW_W-1:0]         in_row,
  input  wire logic [bfgw_pkg::PIX_W-1:0]         in_pixel_in,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [bfgw_pkg::PIX_W-1:0]         out_filtered_pixel,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bfgw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bfgw_pkg::SIZE_W-1:0]        cfg_value
);

  localparam int unsigned CW = bfgw_pkg::COORD_W;
  localparam int unsigned RW = bfgw_pkg::ROW_W;
  localparam int unsigned PW = bfgw_pkg::PIX_W;
  localparam int unsigned SW = bfgw_pkg::SIZE_W;
  localparam int unsigned RADW = bfgw_pkg::RAD_W;
  localparam int unsigned SIDE_W = bfgw_pkg::RAD_W + 1;
  localparam int unsigned RED_W = $clog2(CW);

  bfgw_pkg::state_t state_r, state_nxt;

  logic [SW-1:0]   fw_r, fh_r;
  logic [RADW-1:0] rad_r;
  logic [PW-1:0]   lim_r;

  logic [CW-1:0] wm1, xs_inc, xs_dec;
  logic [RW-1:0] hm1, ys_inc, ys_dec;
  logic [SW-1:0] w_eff, h_eff;

  logic          op_r;
  logic [CW-1:0] col_r, xs_r, x0_r;
  logic [RW-1:0] row_r, ys_r;
  logic [PW-1:0] pix_r, centre_r;
  logic [SW-1:0] rc_r, rr_r, rc_s, rr_s, rc_n, rr_n;
  logic [RED_W-1:0] red_cnt_r;
  logic [RADW-1:0]  bk_r;
  logic [SIDE_W-1:0] cx_r, cy_r, side_m1;
  logic          scan_last, scan_first_r;
  logic          rd_win_r;
  logic [bfgw_pkg::SUM_W-1:0] sum_r;
  logic [bfgw_pkg::CNT_W-1:0] cnt_r;
  logic [PW-1:0] diff;

  logic [PW-1:0] frame_mem [2**bfgw_pkg::ADDR_W];
  logic [PW-1:0] rd_data_r;
  logic [bfgw_pkg::ADDR_W-1:0] rd_addr;
  logic          mem_we;

  logic          div_start;
  bfgw_pkg::div_sts_t div_sts;
  logic [PW-1:0] div_q;

  logic          out_valid_r;
  logic [PW-1:0] out_pix_r;
  logic          out_free, out_load;

  // Effective frame size, clamped to 1..256.
  always_comb begin
    if (fw_r == '0) begin
      wm1 = '0;
    end else if (fw_r > SW'(bfgw_pkg::MAX_WIDTH)) begin
      wm1 = CW'(bfgw_pkg::MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(fw_r - SW'(1));
    end
    if (fh_r == '0) begin
      hm1 = '0;
    end else if (fh_r > SW'(bfgw_pkg::MAX_HEIGHT)) begin
      hm1 = RW'(bfgw_pkg::MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(fh_r - SW'(1));
    end
  end

  assign w_eff = {1'b0, wm1} + SW'(1);
  assign h_eff = {1'b0, hm1} + SW'(1);

  assign xs_inc = (xs_r == wm1) ? '0 : xs_r + CW'(1);
  assign xs_dec = (xs_r == '0) ? wm1 : xs_r - CW'(1);
  assign ys_inc = (ys_r == hm1) ? '0 : ys_r + RW'(1);
  assign ys_dec = (ys_r == '0) ? hm1 : ys_r - RW'(1);

  assign rc_s = {rc_r[SW-2:0], col_r[CW-1]};
  assign rr_s = {rr_r[SW-2:0], row_r[RW-1]};
  assign rc_n = (rc_s >= w_eff) ? rc_s - w_eff : rc_s;
  assign rr_n = (rr_s >= h_eff) ? rr_s - h_eff : rr_s;

  assign side_m1   = {rad_r, 1'b0};
  assign scan_last = (cx_r == side_m1) && (cy_r == side_m1);
  assign diff      = (rd_data_r > centre_r) ? rd_data_r - centre_r : centre_r - rd_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= bfgw_pkg::WIDTH_RST;
      fh_r  <= bfgw_pkg::HEIGHT_RST;
      rad_r <= bfgw_pkg::RADIUS_RST;
      lim_r <= bfgw_pkg::LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bfgw_pkg::CFG_FRAME_WIDTH:  fw_r  <= cfg_value;
        bfgw_pkg::CFG_FRAME_HEIGHT: fh_r  <= cfg_value;
        bfgw_pkg::CFG_RADIUS:       rad_r <= cfg_value[RADW-1:0];
        bfgw_pkg::CFG_LIMIT:        lim_r <= cfg_value[PW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfgw_pkg::ST_IDLE:   if (in_valid) state_nxt = bfgw_pkg::ST_REDUCE;
      bfgw_pkg::ST_REDUCE: begin
        if (red_cnt_r == RED_W'(CW - 1)) begin
          state_nxt = (op_r == bfgw_pkg::OP_LOAD) ? bfgw_pkg::ST_WRITE : bfgw_pkg::ST_BACK;
        end
      end
      bfgw_pkg::ST_WRITE:  state_nxt = bfgw_pkg::ST_IDLE;
      bfgw_pkg::ST_BACK:   if (bk_r == '0) state_nxt = bfgw_pkg::ST_CENTRE;
      bfgw_pkg::ST_CENTRE: state_nxt = bfgw_pkg::ST_SCAN;
      bfgw_pkg::ST_SCAN:   if (scan_last) state_nxt = bfgw_pkg::ST_DRAIN;
      bfgw_pkg::ST_DRAIN:  state_nxt = bfgw_pkg::ST_DSTART;
      bfgw_pkg::ST_DSTART: state_nxt = bfgw_pkg::ST_DIV;
      bfgw_pkg::ST_DIV:    if (div_sts.done) state_nxt = bfgw_pkg::ST_OUT;
      bfgw_pkg::ST_OUT:    if (out_free) state_nxt = bfgw_pkg::ST_IDLE;
      default:             state_nxt = bfgw_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    rd_addr   = {ys_r, xs_r};
    unique case (state_r)
      bfgw_pkg::ST_IDLE:   in_ready  = 1'b1;
      bfgw_pkg::ST_WRITE:  mem_we    = 1'b1;
      bfgw_pkg::ST_CENTRE: rd_addr   = {row_r, col_r};
      bfgw_pkg::ST_DSTART: div_start = 1'b1;
      bfgw_pkg::ST_OUT:    out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfgw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath of the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_win_r     <= 1'b0;
      scan_first_r <= 1'b0;
    end else begin
      rd_win_r     <= (state_r == bfgw_pkg::ST_SCAN);
      scan_first_r <= (state_r == bfgw_pkg::ST_CENTRE);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      bfgw_pkg::ST_IDLE: begin
        op_r      <= in_operation;
        col_r     <= in_column;
        row_r     <= in_row;
        pix_r     <= in_pixel_in;
        rc_r      <= '0;
        rr_r      <= '0;
        red_cnt_r <= '0;
      end
      bfgw_pkg::ST_REDUCE: begin
        red_cnt_r <= red_cnt_r + RED_W'(1);
        if (red_cnt_r == RED_W'(CW - 1)) begin
          col_r <= rc_n[CW-1:0];
          row_r <= rr_n[RW-1:0];
          xs_r  <= rc_n[CW-1:0];
          ys_r  <= rr_n[RW-1:0];
          bk_r  <= rad_r;
        end else begin
          col_r <= {col_r[CW-2:0], 1'b0};
          row_r <= {row_r[RW-2:0], 1'b0};
          rc_r  <= rc_n;
          rr_r  <= rr_n;
        end
      end
      bfgw_pkg::ST_BACK: begin
        if (bk_r != '0) begin
          bk_r <= bk_r - RADW'(1);
          xs_r <= xs_dec;
          ys_r <= ys_dec;
          x0_r <= xs_dec;
        end else begin
          x0_r <= xs_r;
        end
      end
      bfgw_pkg::ST_CENTRE: begin
        cx_r  <= '0;
        cy_r  <= '0;
        sum_r <= '0;
        cnt_r <= '0;
      end
      bfgw_pkg::ST_SCAN: begin
        if (cx_r == side_m1) begin
          cx_r <= '0;
          cy_r <= cy_r + SIDE_W'(1);
          xs_r <= x0_r;
          ys_r <= ys_inc;
        end else begin
          cx_r <= cx_r + SIDE_W'(1);
          xs_r <= xs_inc;
        end
      end
      default: ;
    endcase
    if (scan_first_r) begin
      centre_r <= rd_data_r;
    end
    if (rd_win_r && (diff <= lim_r)) begin
      sum_r <= sum_r + bfgw_pkg::SUM_W'(rd_data_r);
      cnt_r <= cnt_r + bfgw_pkg::CNT_W'(1);
    end
  end

  // Frame store.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[{row_r, col_r}] <= pix_r;
    end
    rd_data_r <= frame_mem[rd_addr];
  end

  bfgw_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r <= div_q;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_pixel = out_pix_r;

endmodule
`default_nettype wire

// ----- src/bfgw_checker.sv -----
// Port checker for the grayscale range-weighted filter and its bind to the top level.
`default_nettype none
module bfgw_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [bfgw_pkg::PIX_W-1:0]   out_filtered_pixel,
  input wire logic                         cfg_ready
);

  a_reset_state: assert property (@(posedge clk) !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while one is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a transaction in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_pixel))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind bilateral_filter_gray_wrap_core bfgw_checker u_bfgw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_filtered_pixel (out_filtered_pixel),
  .cfg_ready          (cfg_ready)
);
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the grayscale range-weighted filter with its frame store.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfgw_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned SETTLE_WAIT  = 300;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 225;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

  typedef enum logic [1:0] {STEP_CFG, STEP_LOAD, STEP_QUERY} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [SIZE_W-1:0]    reg_value;
    logic [7:0]           col;
    logic [7:0]           row;
    logic [7:0]           pix;
    logic                 typed;
    logic [7:0]           want;
  } step_t;

  localparam int unsigned N_STEPS = 35;

  step_t plan [0:N_STEPS-1] = '{
    '{STEP_CFG,   CFG_RADIUS,       9'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_LOAD,  CFG_UNUSED,       9'd0,   8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
    '{STEP_QUERY, CFG_UNUSED,       9'd0,   8'd255, 8'd255, 8'd0,   1'b1, 8'd255},
    '{STEP_LOAD,  CFG_UNUSED,       9'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_QUERY, CFG_UNUSED,       9'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{STEP_CFG,   CFG_FRAME_WIDTH,  9'd8,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_CFG,   CFG_FRAME_HEIGHT, 9'd8,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_LOAD,  CFG_UNUSED,       9'd0,   8'd13,  8'd9,   8'd77,  1'b0, 8'd0},
    '{STEP_QUERY, CFG_UNUSED,       9'd0,   8'd5,   8'd1,   8'd0,   1'b1, 8'd77},
    '{STEP_CFG,   CFG_FRAME_WIDTH,  9'd2,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_CFG,   CFG_FRAME_HEIGHT, 9'd2,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_CFG,   CFG_RADIUS,       9'd1,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_CFG,   CFG_LIMIT,        9'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_LOAD,  CFG_UNUSED,       9'd0,   8'd0,   8'd0,   8'd10,  1'b0, 8'd0},
    '{STEP_LOAD,  CFG_UNUSED,       9'd0,   8'd1,   8'd0,   8'd20,  1'b0, 8'd0},
    '{STEP_LOAD,  CFG_UNUSED,       9'd0,   8'd0,   8'd1,   8'd30,  1'b0, 8'd0},
    '{STEP_LOAD,  CFG_UNUSED,       9'd0,   8'd1,   8'd1,   8'd250, 1'b0, 8'd0},
    '{STEP_QUERY, CFG_UNUSED,       9'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd10},
    '{STEP_QUERY, CFG_UNUSED,       9'd0,   8'd3,   8'd3,   8'd0,   1'b1, 8'd250},
    '{STEP_CFG,   CFG_LIMIT,        9'd255, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_QUERY, CFG_UNUSED,       9'd0,   8'd1,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_CFG,   CFG_LIMIT,        9'd15,  8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_QUERY, CFG_UNUSED,       9'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_CFG,   CFG_FRAME_WIDTH,  9'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_CFG,   CFG_FRAME_HEIGHT, 9'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_CFG,   CFG_RADIUS,       9'd7,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_CFG,   CFG_LIMIT,        9'd255, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_LOAD,  CFG_UNUSED,       9'd0,   8'd37,  8'd200, 8'd200, 1'b0, 8'd0},
    '{STEP_QUERY, CFG_UNUSED,       9'd0,   8'd255, 8'd255, 8'd0,   1'b1, 8'd200},
    '{STEP_CFG,   CFG_FRAME_WIDTH,  9'd300, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_CFG,   CFG_FRAME_HEIGHT, 9'd511, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_CFG,   CFG_RADIUS,       9'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_QUERY, CFG_UNUSED,       9'd0,   8'd255, 8'd255, 8'd0,   1'b1, 8'd255},
    '{STEP_CFG,   CFG_UNUSED,       9'd511, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{STEP_QUERY, CFG_UNUSED,       9'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd200}
  };

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic                 in_operation = OP_LOAD;
  logic [COORD_W-1:0]   in_column    = '0;
  logic [ROW_W-1:0]     in_row       = '0;
  logic [PIX_W-1:0]     in_pixel_in  = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [PIX_W-1:0]     out_filtered_pixel;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [SIZE_W-1:0]    cfg_value    = '0;

  logic [7:0]           frame_copy [0:MAX_WIDTH*MAX_HEIGHT-1];
  bit                   frame_written [0:MAX_WIDTH*MAX_HEIGHT-1];
  logic [SIZE_W-1:0]    cur_width  = WIDTH_RST;
  logic [SIZE_W-1:0]    cur_height = HEIGHT_RST;
  logic [RAD_W-1:0]     cur_radius = RADIUS_RST;
  logic [PIX_W-1:0]     cur_limit  = LIMIT_RST;
  logic [7:0]           pending_pixels [$];
  logic [7:0]           want_pixel;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit          hold_request = 1'b0;
  bit          block_busy = 1'b0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned items_accepted = 0;
  int unsigned loads_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned pixels_checked = 0;

  bilateral_filter_gray_wrap_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_column          (in_column),
    .in_row             (in_row),
    .in_pixel_in        (in_pixel_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_pixel (out_filtered_pixel),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_value          (cfg_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int effective_size(logic [SIZE_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int wrap_to(int pos, int size);
    int m;
    m = pos % size;
    if (m < 0) m += size;
    return m;
  endfunction

  function automatic logic [7:0] filter_window(logic [7:0] col, logic [7:0] row);
    int w, h, c, r, rad, dx, dy, x, y;
    logic [7:0] centre, p, diff;
    int unsigned total, hits;
    w = effective_size(cur_width, MAX_WIDTH);
    h = effective_size(cur_height, MAX_HEIGHT);
    c = wrap_to(int'(col), w);
    r = wrap_to(int'(row), h);
    rad = int'(cur_radius);
    centre = frame_copy[r * MAX_WIDTH + c];
    total = 0;
    hits = 0;
    for (dy = -rad; dy <= rad; dy++) begin
      y = wrap_to(r + dy, h);
      for (dx = -rad; dx <= rad; dx++) begin
        x = wrap_to(c + dx, w);
        p = frame_copy[y * MAX_WIDTH + x];
        diff = (p > centre) ? p - centre : centre - p;
        if (diff <= cur_limit) begin
          total += p;
          hits++;
        end
      end
    end
    if (hits == 0) hits = 1;
    return 8'(total / hits);
  endfunction

  function automatic logic [7:0] near_value(int base);
    int v;
    if ($urandom_range(3) == 0) return 8'($urandom_range(0, 255));
    v = base + int'($urandom_range(0, 48)) - 24;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic push_item(input logic op, input logic [7:0] col, input logic [7:0] row,
                           input logic [7:0] pix, input logic typed, input logic [7:0] want);
    int x, y;
    logic [7:0] next_want;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_column    <= col;
    in_row       <= row;
    in_pixel_in  <= pix;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    block_busy = 1'b1;
    items_accepted++;
    if (op == OP_LOAD) begin
      x = wrap_to(int'(col), effective_size(cur_width, MAX_WIDTH));
      y = wrap_to(int'(row), effective_size(cur_height, MAX_HEIGHT));
      frame_copy[y * MAX_WIDTH + x] = pix;
      frame_written[y * MAX_WIDTH + x] = 1'b1;
      loads_sent++;
    end else begin
      next_want = typed ? want : filter_window(col, row);
      pending_pixels = {pending_pixels, next_want};
      queries_sent++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    block_busy = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
    if (block_busy) settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_value <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH:  cur_width  = value;
      CFG_FRAME_HEIGHT: cur_height = value;
      CFG_RADIUS:       cur_radius = value[RAD_W-1:0];
      CFG_LIMIT:        cur_limit  = value[PIX_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic query_sequence(input logic [7:0] hot_col, input logic [7:0] hot_row);
    logic [7:0] qc, qr;
    int w, h, c, r, rad, base, dx, dy, x, y, extra;
    if ($urandom_range(9) == 0) begin
      qc = 8'($urandom_range(0, 255));
      qr = 8'($urandom_range(0, 255));
    end else begin
      qc = hot_col + 8'($urandom_range(0, 15));
      qr = hot_row + 8'($urandom_range(0, 15));
    end
    w = effective_size(cur_width, MAX_WIDTH);
    h = effective_size(cur_height, MAX_HEIGHT);
    c = wrap_to(int'(qc), w);
    r = wrap_to(int'(qr), h);
    rad = int'(cur_radius);
    base = int'($urandom_range(0, 255));
    for (dy = -rad; dy <= rad; dy++) begin
      for (dx = -rad; dx <= rad; dx++) begin
        x = wrap_to(c + dx, w);
        y = wrap_to(r + dy, h);
        if (!frame_written[y * MAX_WIDTH + x]) begin
          push_item(OP_LOAD, 8'(x), 8'(y), near_value(base), 1'b0, 8'd0);
        end
      end
    end
    extra = ($urandom_range(2) == 0) ? int'($urandom_range(1, 3)) : 0;
    repeat (extra) begin
      x = wrap_to(c + int'($urandom_range(0, 2 * rad)) - rad, w);
      y = wrap_to(r + int'($urandom_range(0, 2 * rad)) - rad, h);
      push_item(OP_LOAD, 8'(x), 8'(y), near_value(base), 1'b0, 8'd0);
    end
    push_item(OP_QUERY, qc, qr, 8'($urandom_range(0, 255)), 1'b0, 8'd0);
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, expected none, actual %0d",
                 $time, out_filtered_pixel);
      end else begin
        want_pixel = pending_pixels.pop_front();
        pixels_checked++;
        if (out_filtered_pixel !== want_pixel) begin
          errors++;
          $display("%0t: filtered_pixel mismatch, expected %0d, actual %0d",
                   $time, want_pixel, out_filtered_pixel);
        end
      end
    end
  end

  initial begin
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        held = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (held != 0) begin
        held--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run stopped after %0d cycles", $time, cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned phase_start;
    int unsigned pw, ph, pr, pl;
    logic [7:0] hot_col, hot_row;
    bit pressure_fired;
    pressure_fired = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_STEPS; i++) begin
      case (plan[i].kind)
        STEP_CFG: write_reg(plan[i].reg_index, plan[i].reg_value);
        STEP_LOAD: push_item(OP_LOAD, plan[i].col, plan[i].row, plan[i].pix, 1'b0, 8'd0);
        default: push_item(OP_QUERY, plan[i].col, plan[i].row, plan[i].pix,
                           plan[i].typed, plan[i].want);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin pw = 8;   ph = 8;   pr = 7; pl = 0;   end
        1: begin pw = 256; ph = 256; pr = 1; pl = 15;  end
        2: begin pw = 256; ph = 8;   pr = 3; pl = 255; end
        3: begin pw = 8;   ph = 256; pr = 0; pl = 40;  end
        default: begin
          pw = $urandom_range(8, 256);
          ph = $urandom_range(8, 256);
          pr = $urandom_range(0, 7);
          pl = $urandom_range(1) ? $urandom_range(0, 40) : $urandom_range(0, 255);
        end
      endcase
      if (p < 3) begin
        send_idle = 18;
        recv_idle = 77;
      end else if (p < 6) begin
        send_idle = 77;
        recv_idle = 18;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(CFG_FRAME_WIDTH, SIZE_W'(pw));
      write_reg(CFG_FRAME_HEIGHT, SIZE_W'(ph));
      write_reg(CFG_RADIUS, SIZE_W'(pr));
      write_reg(CFG_LIMIT, SIZE_W'(pl));
      hot_col = 8'($urandom_range(0, 255));
      hot_row = 8'($urandom_range(0, 255));
      phase_start = items_accepted;
      while (items_accepted - phase_start < PHASE_ITEMS) begin
        if (p == 4 && !pressure_fired && items_accepted - phase_start >= 40) begin
          hold_request = 1'b1;
          pressure_fired = 1'b1;
        end
        if ($urandom_range(99) < 15) begin
          push_item(OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'b0, 8'd0);
        end else begin
          query_sequence(hot_col, hot_row);
        end
      end
    end

    settle();
    $display("Sent %0d loads and %0d queries over %0d filter settings plus the directed table;",
             loads_sent, queries_sent, PHASES);
    $display("%0d filtered pixels were checked, with one long output stall.", pixels_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
